// ===== hw/rtl/positional_list_engine_top_assert.svh =====
// Assertion macros for the positional list engine checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
// No dependencies; used by the top level, ple_ctrl, ple_dpath and ple_checker.
`default_nettype none

package ple_pkg;

    localparam int unsigned DEPTH_DEF = 64;
    localparam int unsigned POS_W     = 7;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned CNT_OUT_W = 7;

    typedef enum logic [2:0] {
        CMD_INS_END   = 3'd0,
        CMD_INS_FRONT = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_REM_END   = 3'd3,
        CMD_REM_FRONT = 3'd4,
        CMD_REM_AT    = 3'd5,
        CMD_READ_AT   = 3'd6,
        CMD_CLEAR     = 3'd7
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_DUP    = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_BADPOS = 3'd4
    } status_t;

    typedef struct packed {
        cmd_code_t                command;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  item_value;
    } ple_cmd_t;

    typedef struct packed {
        status_t                  status;
        logic signed [VAL_W-1:0]  read_value;
        logic [CNT_OUT_W-1:0]     entry_count;
    } ple_rsp_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic fin_dup;
        logic up_init;
        logic shup;
        logic put;
        logic rdpos;
        logic fin_read;
        logic dn_init;
        logic shdn;
        logic fin_rem;
        logic emit;
    } ple_ctl_t;

    typedef struct packed {
        logic pre_done;
        logic pre_ins;
        logic scan_hit;
        logic scan_done;
        logic shup_done;
        logic shdn_done;
        logic is_read;
        logic out_busy;
    } ple_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/positional_list_engine_top.sv =====
// Top level of the positional list engine: ordered list of distinct values.
// Depends on ple_pkg, ple_ctrl and ple_dpath.
//
//   channel  direction  beat type   handshake
//   cmd      in         ple_cmd_t   cmd_valid / cmd_ready
//   rsp      out        ple_rsp_t   rsp_valid / rsp_ready
//
// One command in flight at a time; cmd_ready is high only between commands.
// Error, clear: straight to the response; read_at: reads the entry at pos first.
// Insert: duplicate scan, then shift up to open the slot at pos.
// Remove: reads the entry at pos, then shifts down; the entry memory reads one entry and
// writes one entry per cycle. No clearing pass after reset.
// A stalled response holds in its register while the next command is taken.
`default_nettype none

module positional_list_engine_top #(
    parameter int unsigned DEPTH = ple_pkg::DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire ple_pkg::ple_cmd_t cmd_item,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output ple_pkg::ple_rsp_t      rsp_item
);

    ple_pkg::ple_ctl_t  ctl;
    ple_pkg::ple_stat_t stat;

    ple_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    ple_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .ctl       (ctl),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ple_ctrl.sv =====
// Controller state machine of the positional list engine.
// Depends on ple_pkg; drives ple_dpath through ple_ctl_t.
`default_nettype none

module ple_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire ple_pkg::ple_stat_t stat,
    output ple_pkg::ple_ctl_t      ctl
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_SHUP  = 7'b0000100,
        S_RDVAL = 7'b0001000,
        S_RDGET = 7'b0010000,
        S_SHDN  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        cmd_ready  = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load = 1'b1;
                    if (stat.pre_done)
                    begin
                        state_next = S_DONE;
                    end
                    else if (stat.pre_ins)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RDVAL;
                    end
                end
            end
            S_SCAN:
            begin
                ctl.scan = 1'b1;
                if (stat.scan_hit)
                begin
                    ctl.fin_dup = 1'b1;
                    state_next  = S_DONE;
                end
                else if (stat.scan_done)
                begin
                    ctl.up_init = 1'b1;
                    state_next  = S_SHUP;
                end
            end
            S_SHUP:
            begin
                ctl.shup = 1'b1;
                if (stat.shup_done)
                begin
                    ctl.put    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_RDVAL:
            begin
                ctl.rdpos  = 1'b1;
                state_next = S_RDGET;
            end
            S_RDGET:
            begin
                if (stat.is_read)
                begin
                    ctl.fin_read = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    ctl.dn_init = 1'b1;
                    state_next  = S_SHDN;
                end
            end
            S_SHDN:
            begin
                ctl.shdn = 1'b1;
                if (stat.shdn_done)
                begin
                    ctl.fin_rem = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ple_dpath.sv =====
// Datapath of the positional list engine: entry memory, count, sweep index,
// checks and the response register. Depends on ple_pkg; steered by ple_ctrl.
`default_nettype none

module ple_dpath #(
    parameter int unsigned DEPTH = ple_pkg::DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ple_pkg::ple_cmd_t  cmd_item,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output ple_pkg::ple_rsp_t       rsp_item,
    input  wire ple_pkg::ple_ctl_t  ctl,
    output ple_pkg::ple_stat_t      stat
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned XW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

    logic [ple_pkg::VAL_W-1:0]        mem [DEPTH];
    logic [ple_pkg::VAL_W-1:0]        rd_data_reg;
    logic [AW-1:0]                    rd_addr;
    logic                             rd_en;
    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    logic [ple_pkg::VAL_W-1:0]        mem_wdata;

    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    count_next;
    logic [CW-1:0]                    idx_reg;
    logic [CW-1:0]                    idx_next;
    logic                             cmp_pend_reg;
    logic                             cmp_pend_next;
    logic                             wr_pend_reg;
    logic                             wr_pend_next;
    logic                             rsp_valid_reg;
    logic                             rsp_valid_next;

    logic [AW-1:0]                    pos_reg;
    logic [ple_pkg::VAL_W-1:0]        val_reg;
    logic                             read_reg;
    logic [AW-1:0]                    waddr_reg;
    ple_pkg::status_t                 res_status_reg;
    logic signed [ple_pkg::VAL_W-1:0] res_value_reg;
    ple_pkg::ple_rsp_t                rsp_item_reg;

    logic [XW-1:0]                    count_x;
    logic [XW-1:0]                    pos_x;
    logic [XW-1:0]                    eff_pos_x;
    logic                             is_ins;
    logic                             is_rd;
    logic                             is_clr;
    ple_pkg::status_t                 pre_status;
    logic [CW-1:0]                    idx_m1;
    logic [CW-1:0]                    pos_c;
    logic                             idx_below;
    logic                             up_go;

    assign count_x   = XW'(count_reg);
    assign pos_x     = XW'(cmd_item.position);
    assign idx_m1    = idx_reg - CW'(1);
    assign pos_c     = CW'(pos_reg);
    assign idx_below = (idx_reg < count_reg);
    assign up_go     = (idx_reg > pos_c);

    always_comb
    begin
        is_ins = (cmd_item.command inside {ple_pkg::CMD_INS_END, ple_pkg::CMD_INS_FRONT,
                                           ple_pkg::CMD_INS_AT});
        is_rd  = (cmd_item.command == ple_pkg::CMD_READ_AT);
        is_clr = (cmd_item.command == ple_pkg::CMD_CLEAR);
        case (cmd_item.command)
            ple_pkg::CMD_INS_END:   eff_pos_x = count_x;
            ple_pkg::CMD_INS_FRONT: eff_pos_x = '0;
            ple_pkg::CMD_REM_FRONT: eff_pos_x = '0;
            ple_pkg::CMD_REM_END:   eff_pos_x = count_x - XW'(1);
            default:                eff_pos_x = pos_x;
        endcase
        pre_status = ple_pkg::ST_OK;
        if (is_ins)
        begin
            if (count_x >= XW'(DEPTH))
            begin
                pre_status = ple_pkg::ST_FULL;
            end
            else if (eff_pos_x > count_x)
            begin
                pre_status = ple_pkg::ST_BADPOS;
            end
        end
        else if (!is_clr)
        begin
            if (count_reg == '0)
            begin
                pre_status = ple_pkg::ST_EMPTY;
            end
            else if (eff_pos_x >= count_x)
            begin
                pre_status = ple_pkg::ST_BADPOS;
            end
        end
    end

    always_comb
    begin
        stat.pre_done  = (pre_status != ple_pkg::ST_OK) || is_clr;
        stat.pre_ins   = is_ins;
        stat.scan_hit  = cmp_pend_reg && (rd_data_reg == val_reg);
        stat.scan_done = !idx_below;
        stat.shup_done = (idx_reg == pos_c) && !wr_pend_reg;
        stat.shdn_done = !idx_below && !wr_pend_reg;
        stat.is_read   = read_reg;
        stat.out_busy  = rsp_valid_reg && !rsp_ready;
    end

    always_comb
    begin
        if (ctl.shup)
        begin
            rd_addr = idx_m1[AW-1:0];
        end
        else if (ctl.scan || ctl.shdn)
        begin
            rd_addr = idx_reg[AW-1:0];
        end
        else
        begin
            rd_addr = pos_reg;
        end
        rd_en     = ctl.scan || ctl.shup || ctl.shdn || ctl.rdpos;
        mem_we    = wr_pend_reg || ctl.put;
        mem_waddr = ctl.put ? pos_reg : waddr_reg;
        mem_wdata = ctl.put ? val_reg : rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.load && is_clr)
        begin
            count_next = '0;
        end
        else if (ctl.put)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.fin_rem)
        begin
            count_next = count_reg - CW'(1);
        end

        idx_next      = idx_reg;
        cmp_pend_next = cmp_pend_reg;
        wr_pend_next  = wr_pend_reg;
        if (ctl.load)
        begin
            idx_next      = '0;
            cmp_pend_next = 1'b0;
            wr_pend_next  = 1'b0;
        end
        else if (ctl.up_init)
        begin
            idx_next     = count_reg;
            wr_pend_next = 1'b0;
        end
        else if (ctl.dn_init)
        begin
            idx_next     = pos_c + CW'(1);
            wr_pend_next = 1'b0;
        end
        else if (ctl.scan)
        begin
            cmp_pend_next = idx_below;
            if (idx_below)
            begin
                idx_next = idx_reg + CW'(1);
            end
        end
        else if (ctl.shup)
        begin
            wr_pend_next = up_go;
            if (up_go)
            begin
                idx_next = idx_m1;
            end
        end
        else if (ctl.shdn)
        begin
            wr_pend_next = idx_below;
            if (idx_below)
            begin
                idx_next = idx_reg + CW'(1);
            end
        end

        rsp_valid_next = rsp_valid_reg;
        if (ctl.emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            cmp_pend_reg  <= 1'b0;
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            cmp_pend_reg  <= cmp_pend_next;
            wr_pend_reg   <= wr_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            pos_reg        <= eff_pos_x[AW-1:0];
            val_reg        <= $unsigned(cmd_item.item_value);
            read_reg       <= is_rd;
            res_status_reg <= pre_status;
            res_value_reg  <= '0;
        end
        if (ctl.dn_init)
        begin
            val_reg <= rd_data_reg;
        end
        if (ctl.shup && up_go)
        begin
            waddr_reg <= idx_reg[AW-1:0];
        end
        else if (ctl.shdn && idx_below)
        begin
            waddr_reg <= idx_m1[AW-1:0];
        end
        if (ctl.fin_dup)
        begin
            res_status_reg <= ple_pkg::ST_DUP;
            res_value_reg  <= '0;
        end
        if (ctl.put)
        begin
            res_status_reg <= ple_pkg::ST_OK;
            res_value_reg  <= '0;
        end
        if (ctl.fin_read)
        begin
            res_status_reg <= ple_pkg::ST_OK;
            res_value_reg  <= $signed(rd_data_reg);
        end
        if (ctl.fin_rem)
        begin
            res_status_reg <= ple_pkg::ST_OK;
            res_value_reg  <= $signed(val_reg);
        end
        if (ctl.emit)
        begin
            rsp_item_reg.status      <= res_status_reg;
            rsp_item_reg.read_value  <= res_value_reg;
            rsp_item_reg.entry_count <= count_x[ple_pkg::CNT_OUT_W-1:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ple_checker.sv =====
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine_top_assert.svh.
`default_nettype none

`include "positional_list_engine_top_assert.svh"

module ple_checker #(
    parameter int unsigned DEPTH = ple_pkg::DEPTH_DEF
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cmd_valid,
    input wire logic              cmd_ready,
    input wire ple_pkg::ple_cmd_t cmd_item,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire ple_pkg::ple_rsp_t rsp_item
);

    logic cmd_beat;
    logic cmd_stall;
    logic rsp_stall;
    logic rsp_failed;
    logic rsp_fields_ok;

    assign cmd_beat      = cmd_valid && cmd_ready;
    assign cmd_stall     = cmd_valid && !cmd_ready;
    assign rsp_stall     = rsp_valid && !rsp_ready;
    assign rsp_failed    = rsp_valid && (rsp_item.status != ple_pkg::ST_OK);
    assign rsp_fields_ok = (rsp_item.status inside {[ple_pkg::ST_OK:ple_pkg::ST_BADPOS]})
                           && (32'(rsp_item.entry_count) <= DEPTH);

    `PLE_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_item), "rsp beat moved")
    `PLE_ASSERT_NEXT(a_cmd_hold, cmd_stall, cmd_valid && $stable(cmd_item), "cmd beat moved")
    `PLE_ASSERT_NEXT(a_one_in_flight, cmd_beat, !cmd_ready, "command taken while busy")
    `PLE_ASSERT_NOW(a_rsp_fields, rsp_valid, rsp_fields_ok, "rsp status or count illegal")
    `PLE_ASSERT_NOW(a_fail_zero, rsp_failed, rsp_item.read_value == '0, "data on failure")

endmodule

bind positional_list_engine_top ple_checker #(
    .DEPTH (DEPTH)
) u_ple_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
);

`default_nettype wire

// ===== tb/tb_positional_list_engine_top.sv =====
// Testbench for positional_list_engine_top: directed and random list commands on the cmd channel.
// Checks every rsp beat against an in-bench list predictor; depends on ple_pkg and the RTL.
`default_nettype none

module tb_positional_list_engine_top;

    import ple_pkg::*;

    localparam int unsigned LIST_DEPTH  = DEPTH_DEF;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned SETTLE_CYC  = 300;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    ple_cmd_t cmd_item  = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    ple_rsp_t rsp_item;

    ple_cmd_t          pending_cmds[$];
    ple_rsp_t          expected_rsps[$];
    logic signed [31:0] list_entries[$];

    int unsigned send_idle_pct = 32;
    int unsigned recv_idle_pct = 53;
    int unsigned error_count   = 0;
    int unsigned stall_cycles  = 0;
    bit          filling       = 1'b1;

    positional_list_engine_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic status_t list_insert(int unsigned pos, logic signed [31:0] v);
        if (list_entries.size() >= LIST_DEPTH)
            return ST_FULL;
        if (pos > list_entries.size())
            return ST_BADPOS;
        foreach (list_entries[i])
        begin
            if (list_entries[i] == v)
                return ST_DUP;
        end
        list_entries.insert(pos, v);
        return ST_OK;
    endfunction

    function automatic status_t list_remove(int unsigned pos, output logic signed [31:0] v);
        v = '0;
        if (list_entries.size() == 0)
            return ST_EMPTY;
        if (pos >= list_entries.size())
            return ST_BADPOS;
        v = list_entries[pos];
        list_entries.delete(pos);
        return ST_OK;
    endfunction

    function automatic ple_rsp_t apply_list_command(ple_cmd_t c);
        ple_rsp_t           r;
        logic signed [31:0] v;
        v = '0;
        r.status = ST_OK;
        case (c.command)
            CMD_INS_END:   r.status = list_insert(list_entries.size(), c.item_value);
            CMD_INS_FRONT: r.status = list_insert(0, c.item_value);
            CMD_INS_AT:    r.status = list_insert(c.position, c.item_value);
            CMD_REM_END:
            begin
                if (list_entries.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.status = list_remove(list_entries.size() - 1, v);
            end
            CMD_REM_FRONT: r.status = list_remove(0, v);
            CMD_REM_AT:    r.status = list_remove(c.position, v);
            CMD_READ_AT:
            begin
                if (list_entries.size() == 0)
                    r.status = ST_EMPTY;
                else if (c.position >= list_entries.size())
                    r.status = ST_BADPOS;
                else
                    v = list_entries[c.position];
            end
            default:       list_entries.delete();
        endcase
        r.read_value  = (r.status == ST_OK) ? v : '0;
        r.entry_count = 7'(list_entries.size());
        return r;
    endfunction

    // driver: predict on each accepted cmd beat, then load the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
                expected_rsps.push_back(apply_list_command(cmd_item));
            if (!cmd_valid || cmd_ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_item  <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        ple_rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected rsp beat status %0d value %0d count %0d", $time,
                             rsp_item.status, rsp_item.read_value, rsp_item.entry_count);
                    error_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_item.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, rsp_item.status);
                        error_count++;
                    end
                    if (rsp_item.read_value !== want.read_value)
                    begin
                        $display("%0t: read_value expected %0d actual %0d", $time,
                                 want.read_value, rsp_item.read_value);
                        error_count++;
                    end
                    if (rsp_item.entry_count !== want.entry_count)
                    begin
                        $display("%0t: entry_count expected %0d actual %0d", $time,
                                 want.entry_count, rsp_item.entry_count);
                        error_count++;
                    end
                end
            end
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) ||
                (pending_cmds.size() == 0 && !cmd_valid && expected_rsps.size() == 0))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, stall_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic queue_cmd(cmd_code_t c, int unsigned pos, logic [31:0] v);
        ple_cmd_t b;
        while (pending_cmds.size() != 0)
            @(negedge clk);
        b.command    = c;
        b.position   = 7'(pos);
        b.item_value = v;
        pending_cmds.push_back(b);
    endtask

    task automatic wait_list_idle();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || expected_rsps.size() != 0);
    endtask

    // mostly fill-then-drain sweeps with random content; a little noise
    task automatic send_random_cmds(int unsigned n);
        int unsigned roll;
        int unsigned cnt;
        int unsigned pos;
        logic [31:0] v;
        cmd_code_t   c;
        repeat (n)
        begin
            while (pending_cmds.size() != 0)
                @(negedge clk);
            cnt = list_entries.size();
            if (cnt >= LIST_DEPTH && $urandom_range(3) == 0)
                filling = 1'b0;
            else if (cnt == 0 && $urandom_range(3) == 0)
                filling = 1'b1;
            roll = $urandom_range(99);
            pos  = $urandom_range(127);
            v    = $urandom;
            if (roll < 2)
                c = CMD_CLEAR;
            else if (roll < 5)
                c = cmd_code_t'($urandom_range(7));
            else if (roll < 13)
            begin
                c = CMD_READ_AT;
                if (cnt != 0 && $urandom_range(9) != 0)
                    pos = $urandom_range(cnt - 1);
            end
            else if ((roll < 70) == filling)
            begin
                c = cmd_code_t'($urandom_range(CMD_INS_AT));
                if ($urandom_range(9) != 0)
                    pos = $urandom_range(cnt);
                roll = $urandom_range(99);
                if (roll < 15)
                    v = $urandom_range(15);
                else if (roll < 22)
                    case ($urandom_range(3))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7fff_ffff;
                        2: v = 32'hffff_ffff;
                        default: v = 32'h0000_0000;
                    endcase
                else if (roll < 32 && cnt != 0)
                    v = list_entries[$urandom_range(cnt - 1)];
            end
            else
            begin
                c = cmd_code_t'($urandom_range(CMD_REM_AT, CMD_REM_END));
                if (cnt != 0 && $urandom_range(9) != 0)
                    pos = $urandom_range(cnt - 1);
            end
            queue_cmd(c, pos, v);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_cmd(CMD_REM_END, 0, 32'h0);
        queue_cmd(CMD_REM_FRONT, 0, 32'h0);
        queue_cmd(CMD_REM_AT, 0, 32'h0);
        queue_cmd(CMD_READ_AT, 0, 32'h0);
        queue_cmd(CMD_INS_AT, 1, 32'h5);
        queue_cmd(CMD_INS_END, 0, 32'h7fff_ffff);
        queue_cmd(CMD_INS_FRONT, 0, 32'h8000_0000);
        queue_cmd(CMD_INS_AT, 2, 32'h0);
        queue_cmd(CMD_INS_AT, 1, 32'hffff_ffff);
        queue_cmd(CMD_INS_END, 0, 32'h7fff_ffff);
        queue_cmd(CMD_INS_AT, 127, 32'h5555_5555);
        queue_cmd(CMD_READ_AT, 0, 32'h0);
        queue_cmd(CMD_READ_AT, 3, 32'h0);
        queue_cmd(CMD_READ_AT, 4, 32'h0);
        queue_cmd(CMD_READ_AT, 127, 32'h0);
        queue_cmd(CMD_REM_AT, 127, 32'h0);
        queue_cmd(CMD_REM_AT, 1, 32'h0);
        queue_cmd(CMD_REM_FRONT, 64, 32'h0);
        queue_cmd(CMD_REM_END, 0, 32'h0);
        queue_cmd(CMD_INS_AT, 0, 32'haaaa_aaaa);
        queue_cmd(CMD_CLEAR, 0, 32'h0);
        queue_cmd(CMD_CLEAR, 127, 32'hffff_ffff);

        send_random_cmds(340);
        wait_list_idle();
        send_idle_pct = 53;
        recv_idle_pct = 32;
        send_random_cmds(340);
        wait_list_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_cmds(320);
        wait_list_idle();
        repeat (SETTLE_CYC) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
